FILE: rtl/obbso_pkg.sv
package obbso_pkg;

  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = 3;
  localparam int REG_LSB    = 3;
  localparam int NUM_STAGES = 8;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BOX_CENTER = 3'd0,
    REG_AXIS_A     = 3'd1,
    REG_AXIS_B     = 3'd2,
    REG_AXIS_C     = 3'd3,
    REG_HALF_EXT   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic s5;
    logic s6;
    logic s7;
  } cross_en_t;

endpackage

FILE: rtl/obbso_cross.sv
module obbso_cross #(
  parameter int MAG_W = 38,
  parameter int DIR_W = 37,
  parameter int SC_W  = 35
) (
  input  logic                 clk_i,
  input  obbso_pkg::cross_en_t en_i,
  input  logic [MAG_W-1:0]     ma_mag_i,
  input  logic                 ma_neg_i,
  input  logic [MAG_W-1:0]     mb_mag_i,
  input  logic                 mb_neg_i,
  input  logic [DIR_W-1:0]     da_mag_i,
  input  logic                 da_neg_i,
  input  logic [DIR_W-1:0]     db_mag_i,
  input  logic                 db_neg_i,
  input  logic [DIR_W-1:0]     da_inc_i,
  input  logic [DIR_W-1:0]     db_inc_i,
  input  logic [SC_W-1:0]      sa_i,
  input  logic [SC_W-1:0]      sb_i,
  output logic                 sep_o
);
  import obbso_pkg::*;

  localparam int H    = (MAG_W + 1) / 2;
  localparam int PP_W = 2 * H;
  localparam int PR_W = 4 * H;
  localparam int CW   = PR_W + 3;

  logic [PP_W-1:0] opa [4];
  logic [PP_W-1:0] opb [4];
  logic [PP_W-1:0] pp_q [4][4];
  logic [PR_W-1:0] prod_q [4];
  logic            neg0_q5, neg1_q5, neg0_q6, neg1_q6;
  logic signed [CW-1:0] lhs_d, rhs_d, lhs_q, rhs_q;
  logic signed [CW:0]   sum;

  assign opa[0] = PP_W'(ma_mag_i);
  assign opb[0] = PP_W'(db_mag_i);
  assign opa[1] = PP_W'(mb_mag_i);
  assign opb[1] = PP_W'(da_mag_i);
  assign opa[2] = PP_W'(sa_i);
  assign opb[2] = PP_W'(db_inc_i);
  assign opa[3] = PP_W'(sb_i);
  assign opb[3] = PP_W'(da_inc_i);

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      for (int t = 0; t < 4; t++) begin
        pp_q[t][0] <= PP_W'(opa[t][H-1:0]) * PP_W'(opb[t][H-1:0]);
        pp_q[t][1] <= PP_W'(opa[t][H-1:0]) * PP_W'(opb[t][PP_W-1:H]);
        pp_q[t][2] <= PP_W'(opa[t][PP_W-1:H]) * PP_W'(opb[t][H-1:0]);
        pp_q[t][3] <= PP_W'(opa[t][PP_W-1:H]) * PP_W'(opb[t][PP_W-1:H]);
      end
      neg0_q5 <= ma_neg_i ^ db_neg_i;
      neg1_q5 <= mb_neg_i ^ da_neg_i;
    end
  end

  // merge partials
  always_ff @(posedge clk_i) begin
    if (en_i.s6) begin
      for (int t = 0; t < 4; t++) begin
        prod_q[t] <= (PR_W'(pp_q[t][3]) << (2 * H)) + (PR_W'(pp_q[t][1]) << H)
                   + (PR_W'(pp_q[t][2]) << H) + PR_W'(pp_q[t][0]);
      end
      neg0_q6 <= neg0_q5;
      neg1_q6 <= neg1_q5;
    end
  end

  always_comb begin
    logic signed [CW-1:0] x0, x1;
    x0 = $signed(CW'(prod_q[0]));
    x1 = $signed(CW'(prod_q[1]));
    lhs_d = (neg0_q6 ? -x0 : x0) - (neg1_q6 ? -x1 : x1);
    rhs_d = $signed(CW'(prod_q[2])) + $signed(CW'(prod_q[3]));
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s7) begin
      lhs_q <= lhs_d;
      rhs_q <= rhs_d;
    end
  end

  assign sum   = (CW+1)'(lhs_q) + (CW+1)'(rhs_q);
  assign sep_o = (lhs_q > rhs_q) || sum[CW];

endmodule

FILE: rtl/obb_segment_overlap_test.sv
// Channel   Dir  Handshake                Content
// s_axis    in   tvalid/tready            segment start and end points
// m_axis    out  tvalid/tready            hit flag
// apb       in   psel/penable/pready      box center, axis rows, half extents
//
// One segment per cycle sustained while m_axis_tready stays high; a stall
// holds the flow. m_axis_tvalid is the valid bit of the last stage of the
// eight-stage datapath: midpoint and direction, dot products, sums,
// magnitudes, partial products and face test, merge, cross terms, compare.
// Reset clears valid bits and loads the identity axis rows.
// A stall holds each full stage; empty stages keep filling behind it.
module obb_segment_overlap_test #(
  parameter int COORD_BITS = 20,
  parameter int AXIS_BITS  = 16,
  localparam int TDATA_W   = ((6 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z
  input  logic [TDATA_W-1:0]               s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // hit
  output logic [7:0]                       m_axis_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [obbso_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [obbso_pkg::APB_DATA_W-1:0] pwdata,
  output logic [obbso_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);
  import obbso_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int AB    = AXIS_BITS;
  localparam int M2_W  = CB + 2;
  localparam int D2_W  = CB + 1;
  localparam int PM_W  = AB + M2_W;
  localparam int PD_W  = AB + D2_W;
  localparam int MW_W  = AB + CB + 4;
  localparam int DW_W  = AB + CB + 3;
  localparam int MM_W  = AB + CB + 2;
  localparam int DM_W  = AB + CB + 1;
  localparam int SC_W  = CB + AB - 1;
  localparam int FW    = MM_W + 1;
  localparam logic [3*AB-1:0] ONE_AXIS = (3*AB)'(1) << (AB - 2);

  // configuration
  logic [3*CB-1:0]        center_q, half_q;
  logic [3*AB-1:0]        axis_q [3];
  logic [REG_IDX_W-1:0]   cfg_idx;
  logic                   cfg_we;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[APB_ADDR_W-1:REG_LSB];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q  <= '0;
      half_q    <= '0;
      axis_q[0] <= ONE_AXIS;
      axis_q[1] <= ONE_AXIS << AB;
      axis_q[2] <= ONE_AXIS << (2 * AB);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BOX_CENTER: center_q  <= pwdata[3*CB-1:0];
        REG_AXIS_A:     axis_q[0] <= pwdata[3*AB-1:0];
        REG_AXIS_B:     axis_q[1] <= pwdata[3*AB-1:0];
        REG_AXIS_C:     axis_q[2] <= pwdata[3*AB-1:0];
        REG_HALF_EXT:   half_q    <= pwdata[3*CB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BOX_CENTER: prdata = APB_DATA_W'(center_q);
      REG_AXIS_A:     prdata = APB_DATA_W'(axis_q[0]);
      REG_AXIS_B:     prdata = APB_DATA_W'(axis_q[1]);
      REG_AXIS_C:     prdata = APB_DATA_W'(axis_q[2]);
      REG_HALF_EXT:   prdata = APB_DATA_W'(half_q);
      default:        prdata = '0;
    endcase
  end

  // pipeline control
  logic [NUM_STAGES:1]   vld_q, vin;
  logic [NUM_STAGES+1:1] rdy;
  cross_en_t             cross_en;

  assign vin = {vld_q[NUM_STAGES-1:1], s_axis_tvalid};

  always_comb begin
    rdy[NUM_STAGES+1] = m_axis_tready;
    for (int k = NUM_STAGES; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  assign s_axis_tready = rdy[1];
  assign cross_en.s5   = rdy[5];
  assign cross_en.s6   = rdy[6];
  assign cross_en.s7   = rdy[7];

  // field slices
  logic signed [CB-1:0] pt_s [3];
  logic signed [CB-1:0] pt_e [3];
  logic signed [CB-1:0] ctr  [3];
  logic signed [AB-1:0] ax   [3][3];
  logic [SC_W-1:0]      sc   [3];

  for (genvar j = 0; j < 3; j++) begin : g_slice
    assign pt_s[j] = $signed(s_axis_tdata[j*CB +: CB]);
    assign pt_e[j] = $signed(s_axis_tdata[(3+j)*CB +: CB]);
    assign ctr[j]  = $signed(center_q[j*CB +: CB]);
    assign sc[j]   = {half_q[j*CB +: CB], {(AB-1){1'b0}}};
    for (genvar i = 0; i < 3; i++) begin : g_ax
      assign ax[i][j] = $signed(axis_q[i][j*AB +: AB]);
    end
  end

  // stage 1: doubled midpoint and direction
  logic signed [M2_W-1:0] m2_q [3];
  logic signed [D2_W-1:0] d2_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      for (int j = 0; j < 3; j++) begin
        m2_q[j] <= M2_W'(pt_s[j]) + M2_W'(pt_e[j]) - (M2_W'(ctr[j]) <<< 1);
        d2_q[j] <= D2_W'(pt_e[j]) - D2_W'(pt_s[j]);
      end
    end
  end

  // stage 2: projection products
  logic signed [PM_W-1:0] pm_q [3][3];
  logic signed [PD_W-1:0] pd_q [3][3];

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pm_q[i][j] <= PM_W'(ax[i][j]) * PM_W'(m2_q[j]);
          pd_q[i][j] <= PD_W'(ax[i][j]) * PD_W'(d2_q[j]);
        end
      end
    end
  end

  // stage 3: dot product sums
  logic signed [MW_W-1:0] mw_q [3];
  logic signed [DW_W-1:0] dw_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        mw_q[i] <= MW_W'(pm_q[i][0]) + MW_W'(pm_q[i][1]) + MW_W'(pm_q[i][2]);
        dw_q[i] <= DW_W'(pd_q[i][0]) + DW_W'(pd_q[i][1]) + DW_W'(pd_q[i][2]);
      end
    end
  end

  // stage 4: magnitudes
  logic [MM_W-1:0] mmag_q [3];
  logic [DM_W-1:0] dmag_q [3];
  logic [DM_W-1:0] dinc_q [3];
  logic [2:0]      mneg_q, dneg_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      for (int i = 0; i < 3; i++) begin
        mneg_q[i] <= mw_q[i][MW_W-1];
        dneg_q[i] <= dw_q[i][DW_W-1];
        mmag_q[i] <= mw_q[i][MW_W-1] ? MM_W'(-mw_q[i]) : MM_W'(mw_q[i]);
        dmag_q[i] <= dw_q[i][DW_W-1] ? DM_W'(-dw_q[i]) : DM_W'(dw_q[i]);
        dinc_q[i] <= dw_q[i][DW_W-1] ? DM_W'(~dw_q[i] + DW_W'(2))
                                      : DM_W'(dw_q[i] + DW_W'(1));
      end
    end
  end

  // stages 5 to 7: face tests, carry; stage 8: hit result
  logic [2:0] face_q5, face_q6, face_q7;
  logic [2:0] cross_sep;
  logic       hit_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      for (int i = 0; i < 3; i++) begin
        face_q5[i] <= FW'(mmag_q[i]) > (FW'(sc[i]) + FW'(dmag_q[i]));
      end
    end
    if (rdy[6]) begin
      face_q6 <= face_q5;
    end
    if (rdy[7]) begin
      face_q7 <= face_q6;
    end
    if (rdy[8]) begin
      hit_q <= !(|face_q7) && !(|cross_sep);
    end
  end

  for (genvar p = 0; p < 3; p++) begin : g_cross
    localparam int A = (p + 1) % 3;
    localparam int B = (p + 2) % 3;
    obbso_cross #(
      .MAG_W (MM_W),
      .DIR_W (DM_W),
      .SC_W  (SC_W)
    ) u_cross (
      .clk_i    (clk_i),
      .en_i     (cross_en),
      .ma_mag_i (mmag_q[A]),
      .ma_neg_i (mneg_q[A]),
      .mb_mag_i (mmag_q[B]),
      .mb_neg_i (mneg_q[B]),
      .da_mag_i (dmag_q[A]),
      .da_neg_i (dneg_q[A]),
      .db_mag_i (dmag_q[B]),
      .db_neg_i (dneg_q[B]),
      .da_inc_i (dinc_q[A]),
      .db_inc_i (dinc_q[B]),
      .sa_i     (sc[A]),
      .sb_i     (sc[B]),
      .sep_o    (cross_sep[p])
    );
  end

  assign m_axis_tvalid = vld_q[NUM_STAGES];
  assign m_axis_tdata  = {7'd0, hit_q};

  a_first_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vld_q[1]) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("stage 1 filled without an accepted request");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && !rdy[2] |=> vld_q[1])
    else $error("stage 1 dropped an item while blocked");

  a_ready_with_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&vld_q) |-> s_axis_tready)
    else $error("input stalled while the pipeline has a bubble");

  a_cfg_axis_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we && (cfg_idx == REG_AXIS_B) |=> axis_q[1] == $past(pwdata[3*AB-1:0]))
    else $error("axis row b write lost");

endmodule

FILE: tb/sv/obb_segment_overlap_test_tb.sv
module obb_segment_overlap_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import obbso_pkg::*;

  localparam int CW          = 20;
  localparam int AW          = 16;
  localparam int AXIS_ONE    = 1 << (AW - 2);
  localparam int AXIS_DIAG   = 11585;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REG_SPARE   = REG_HALF_EXT + 1;
  localparam int REG_TOP     = (1 << REG_IDX_W) - 1;

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [127:0]   wide_t;
  typedef logic [APB_DATA_W-1:0] word_t;

  // start_x in the low bits, end_z in the high bits
  typedef struct packed {
    coord_t end_z;
    coord_t end_y;
    coord_t end_x;
    coord_t start_z;
    coord_t start_y;
    coord_t start_x;
  } segment_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // start_x, start_y, start_z, end_x, end_y, end_z
  logic [$bits(segment_t)-1:0] s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // hit
  logic [7:0]            m_axis_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic [3*CW-1:0] box_center;
  logic [3*AW-1:0] axis_row [3];
  logic [3*CW-1:0] half_ext;

  bit   hit_queue [$];
  int   mismatches;
  int   results_seen;
  int   cycle_count;
  int   sink_hold;
  bit   src_idle_en;
  bit   sink_idle_en;

  obb_segment_overlap_test DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("obb_segment_overlap_test_tb: errors");
    $finish;
  end

  function automatic longint mag64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit axis_pair_separates(longint ma, longint mb, longint da, longint db,
                                             longint sa, longint sb);
    wide_t lhs;
    wide_t rhs;
    lhs = wide_t'(ma) * wide_t'(db) - wide_t'(mb) * wide_t'(da);
    if (lhs < 0) lhs = -lhs;
    rhs = wide_t'(sa) * (wide_t'(mag64(db)) + 1) + wide_t'(sb) * (wide_t'(mag64(da)) + 1);
    return lhs > rhs;
  endfunction

  function automatic bit box_hit(segment_t sg);
    coord_t               p0 [3];
    coord_t               p1 [3];
    coord_t               c;
    logic signed [AW-1:0] ax;
    longint               m2 [3];
    longint               d2 [3];
    longint               mw [3];
    longint               dw [3];
    longint               sc [3];
    bit                   hit;
    p0  = '{sg.start_x, sg.start_y, sg.start_z};
    p1  = '{sg.end_x, sg.end_y, sg.end_z};
    hit = 1'b1;
    for (int j = 0; j < 3; j++) begin
      c     = box_center[CW*j +: CW];
      m2[j] = p0[j] + p1[j] - 2 * c;
      d2[j] = p1[j] - p0[j];
    end
    for (int i = 0; i < 3; i++) begin
      mw[i] = 0;
      dw[i] = 0;
      for (int j = 0; j < 3; j++) begin
        ax    = axis_row[i][AW*j +: AW];
        mw[i] += ax * m2[j];
        dw[i] += ax * d2[j];
      end
      sc[i] = longint'(half_ext[CW*i +: CW]) << (AW - 1);
      if (mag64(mw[i]) > sc[i] + mag64(dw[i])) hit = 1'b0;
    end
    if (axis_pair_separates(mw[1], mw[2], dw[1], dw[2], sc[1], sc[2])) hit = 1'b0;
    if (axis_pair_separates(mw[2], mw[0], dw[2], dw[0], sc[2], sc[0])) hit = 1'b0;
    if (axis_pair_separates(mw[0], mw[1], dw[0], dw[1], sc[0], sc[1])) hit = 1'b0;
    return hit;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < 50) $display("mismatch at result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  always @(negedge clk_i) begin : check_results
    bit want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (hit_queue.size() == 0) begin
        report_mismatch($sformatf("unrequested result tdata=%0h", m_axis_tdata));
      end else begin
        want = hit_queue.pop_front();
        if (m_axis_tdata !== {7'b0, want})
          report_mismatch($sformatf("hit expected %0d, tdata=%0h", want, m_axis_tdata));
      end
      results_seen++;
    end
  end

  // hold off while sink_hold is nonzero, else stall at random when sink_idle_en is set
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold--;
    end else begin
      m_axis_tready <= !(sink_idle_en && $urandom_range(99) < 26);
    end
  end

  function automatic segment_t make_seg(int sx, int sy, int sz, int ex, int ey, int ez);
    segment_t sg;
    sg.start_x = coord_t'(sx);
    sg.start_y = coord_t'(sy);
    sg.start_z = coord_t'(sz);
    sg.end_x   = coord_t'(ex);
    sg.end_y   = coord_t'(ey);
    sg.end_z   = coord_t'(ez);
    return sg;
  endfunction

  function automatic word_t pack_coords(int x, int y, int z);
    return word_t'({CW'(z), CW'(y), CW'(x)});
  endfunction

  function automatic word_t pack_axis(int x, int y, int z);
    return word_t'({AW'(z), AW'(y), AW'(x)});
  endfunction

  function automatic word_t unit_row(int k, bit neg);
    int v [3];
    v    = '{0, 0, 0};
    v[k] = neg ? -AXIS_ONE : AXIS_ONE;
    return pack_axis(v[0], v[1], v[2]);
  endfunction

  function automatic int rand_span(int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  function automatic int corner_coord();
    case ($urandom_range(4))
      0: return int'(COORD_MIN);
      1: return int'(COORD_MAX);
      2: return 0;
      3: return -1;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic segment_t random_segment(int spread);
    int p [3];
    int q [3];
    int pick;
    pick = int'($urandom_range(99));
    for (int j = 0; j < 3; j++) begin
      p[j] = int'($signed(box_center[CW*j +: CW])) + rand_span(spread);
      q[j] = int'($signed(box_center[CW*j +: CW])) + rand_span(spread);
      if (pick >= 60 && pick < 75) q[j] = int'($urandom);
      if (pick >= 75 && pick < 85) begin
        p[j] = int'($urandom);
        q[j] = int'($urandom);
      end
      if (pick >= 85 && pick < 95) begin
        p[j] = corner_coord();
        q[j] = corner_coord();
      end
      if (pick >= 95) q[j] = p[j];
    end
    return make_seg(p[0], p[1], p[2], q[0], q[1], q[2]);
  endfunction

  task automatic send_segment(segment_t sg);
    while (src_idle_en && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sg;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    hit_queue.push_back(box_hit(sg));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(int idx, word_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx << REG_LSB);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_BOX_CENTER: box_center  = value[3*CW-1:0];
      REG_AXIS_A:     axis_row[0] = value[3*AW-1:0];
      REG_AXIS_B:     axis_row[1] = value[3*AW-1:0];
      REG_AXIS_C:     axis_row[2] = value[3*AW-1:0];
      REG_HALF_EXT:   half_ext    = value[3*CW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_box(word_t center, word_t ra, word_t rb, word_t rc, word_t half);
    drain();
    write_reg(REG_BOX_CENTER, center);
    write_reg(REG_AXIS_A, ra);
    write_reg(REG_AXIS_B, rb);
    write_reg(REG_AXIS_C, rc);
    write_reg(REG_HALF_EXT, half);
  endtask

  task automatic test_reset_defaults();
    send_segment(make_seg(-256, 0, 0, 256, 0, 0));
    send_segment(make_seg(0, 0, 0, 0, 0, 0));
    send_segment(make_seg(256, 256, 0, 512, 512, 0));
    send_segment(make_seg(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
    send_segment(make_seg(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    send_segment(make_seg(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_segment(make_seg(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
    send_segment(make_seg(-1, -1, -1, 0, 0, 0));
  endtask

  task automatic test_directed_box();
    load_box(pack_coords(25600, -12800, 6400), unit_row(0, 1'b0), unit_row(1, 1'b0),
             unit_row(2, 1'b0), pack_coords(2560, 5120, 7680));
    send_segment(make_seg(25600, -12800, 6400, 25700, -12700, 6500));
    send_segment(make_seg(20000, -12800, 6400, 31000, -12800, 6400));
    send_segment(make_seg(28200, -12800, 6400, 30000, -12800, 6400));
    send_segment(make_seg(25600, -7600, 6400, 25600, -6000, 6400));
    send_segment(make_seg(25600, -12800, 14100, 25600, -12800, 15000));
    // diagonal just past the box edge: only a cross axis separates it
    send_segment(make_seg(31000, -10320, 6400, 24000, -3320, 6400));
    send_segment(make_seg(31000, -10720, 6400, 24000, -3720, 6400));
    send_segment(make_seg(25600, -12800, 6400, 25600, -12800, 6400));
    send_segment(make_seg(40000, 0, 0, 40000, 0, 0));
  endtask

  task automatic test_degenerate_box();
    load_box(pack_coords(512, 0, -512), '0, '0, '0, '0);
    send_segment(make_seg(COORD_MAX, 0, 0, COORD_MAX, 0, 0));
    send_segment(make_seg(1000, -2000, 3000, -4000, 5000, -6000));
    load_box(pack_coords(512, 0, -512), pack_axis(AXIS_ONE, AXIS_ONE, 0),
             pack_axis(0, AXIS_ONE / 2, 0), pack_axis(-AXIS_ONE, 0, AXIS_ONE),
             pack_coords(300, 1000, 200));
    send_segment(make_seg(512, 0, -512, 600, 100, -400));
    send_segment(make_seg(3000, 3000, 3000, 4000, -3000, 2000));
    // writes past the last register must leave the box as it is
    drain();
    for (int idx = REG_SPARE; idx <= REG_TOP; idx++)
      write_reg(idx, {$urandom, $urandom});
    send_segment(make_seg(512, 0, -512, 700, 200, -300));
    send_segment(make_seg(-5000, 0, 0, 5000, 0, 0));
  endtask

  task automatic test_aligned_boxes();
    int p;
    int hx;
    int hy;
    int hz;
    repeat (4) begin
      p  = int'($urandom_range(2));
      hx = int'($urandom_range(8192));
      hy = int'($urandom_range(8192));
      hz = int'($urandom_range(8192));
      load_box(pack_coords(rand_span(65536), rand_span(65536), rand_span(65536)),
               unit_row(p, 1'($urandom_range(1))), unit_row((p + 1) % 3, 1'($urandom_range(1))),
               unit_row((p + 2) % 3, 1'($urandom_range(1))), pack_coords(hx, hy, hz));
      repeat (75) send_segment(random_segment(2 * (hx + hy + hz) + 256));
    end
  endtask

  task automatic test_rotated_boxes();
    int hx;
    int hy;
    int hz;
    repeat (4) begin
      hx = int'($urandom_range(4096));
      hy = int'($urandom_range(4096));
      hz = int'($urandom_range(4096));
      load_box(pack_coords(rand_span(65536), rand_span(65536), rand_span(65536)),
               pack_axis(AXIS_DIAG + rand_span(40), AXIS_DIAG + rand_span(40), rand_span(40)),
               pack_axis(-AXIS_DIAG + rand_span(40), AXIS_DIAG + rand_span(40), rand_span(40)),
               pack_axis(rand_span(40), rand_span(40), AXIS_ONE + rand_span(40)),
               pack_coords(hx, hy, hz));
      repeat (75) send_segment(random_segment(2 * (hx + hy + hz) + 256));
    end
  endtask

  task automatic test_no_idle();
    load_box(pack_coords(rand_span(4096), rand_span(4096), rand_span(4096)),
             pack_axis(AXIS_ONE, 0, 0), pack_axis(0, AXIS_DIAG, -AXIS_DIAG),
             pack_axis(0, AXIS_DIAG, AXIS_DIAG), pack_coords(2000, 3000, 1500));
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (250) send_segment(random_segment(8000));
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    drain();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    @(negedge clk_i);
    sink_hold = 80;
    @(posedge clk_i);
    repeat (48) send_segment(random_segment(8000));
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  task automatic test_random_registers();
    repeat (5) begin
      load_box({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom});
      repeat (50) send_segment(random_segment(1 << 17));
    end
  endtask

  task automatic test_extreme_registers();
    load_box('1, '1, '1, '1, '1);
    repeat (50) send_segment(random_segment(1 << 17));
    load_box('0, '0, '0, '0, '0);
    repeat (50) send_segment(random_segment(1 << 17));
    load_box(pack_coords(COORD_MIN, COORD_MIN, COORD_MIN),
             pack_axis(-(1 << (AW - 1)), -(1 << (AW - 1)), -(1 << (AW - 1))),
             pack_axis(-(1 << (AW - 1)), -(1 << (AW - 1)), -(1 << (AW - 1))),
             pack_axis(-(1 << (AW - 1)), -(1 << (AW - 1)), -(1 << (AW - 1))),
             pack_coords(-1, -1, -1));
    repeat (50) send_segment(random_segment(1 << 17));
    load_box(pack_coords(COORD_MAX, COORD_MAX, COORD_MAX),
             pack_axis((1 << (AW - 1)) - 1, (1 << (AW - 1)) - 1, (1 << (AW - 1)) - 1),
             pack_axis((1 << (AW - 1)) - 1, 0, (1 << (AW - 1)) - 1),
             pack_axis(0, (1 << (AW - 1)) - 1, 0), '0);
    repeat (50) send_segment(random_segment(1 << 17));
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    box_center    = '0;
    axis_row[0]   = unit_row(0, 1'b0);
    axis_row[1]   = unit_row(1, 1'b0);
    axis_row[2]   = unit_row(2, 1'b0);
    half_ext      = '0;
    mismatches    = 0;
    results_seen  = 0;
    sink_hold     = 0;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_box();
    test_degenerate_box();
    test_aligned_boxes();
    test_rotated_boxes();
    test_no_idle();
    test_backpressure();
    test_random_registers();
    test_extreme_registers();
    drain();
    repeat (24) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("obb_segment_overlap_test_tb: clean");
    end else begin
      $display("obb_segment_overlap_test_tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/obbso_pkg.sv
rtl/obbso_cross.sv
rtl/obb_segment_overlap_test.sv
tb/sv/obb_segment_overlap_test_tb.sv
